[hw/rtl/ksa_pkg.sv]
// Package for the keyed slot allocator: shared types, codes and defaults.
// Used by ksa_cell and keyed_slot_allocator_with_expiry; depends on nothing.
package ksa_pkg;

  localparam int unsigned SlotCountDefault = 32;

  localparam int unsigned KeyW    = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned LifeW   = 16;
  localparam int unsigned IndexW  = 5;
  localparam int unsigned FoundW  = 2;

  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 8;

  localparam logic [FoundW-1:0] FOUND_KEY     = 2'd0;
  localparam logic [FoundW-1:0] FOUND_EXPIRED = 2'd1;
  localparam logic [FoundW-1:0] FOUND_FORCED  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_GRANT
  } ksa_state_e;

  // Request broadcast to every cell.
  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [TimeW-1:0] now;
    logic [TimeW-1:0] expiry;
  } req_t;

  // Per-cycle control broadcast to every cell.
  typedef struct packed {
    logic cmp_en;
    logic wr_en;
  } cell_ctrl_t;

  // Priority chain handed from a cell to its upper neighbor.
  typedef struct packed {
    logic match_seen;
    logic exp_seen;
  } chain_t;

  // Global outcome of the chain, seen by every cell.
  typedef struct packed {
    logic any_match;
    logic any_exp;
  } chain_sum_t;

endpackage

[hw/rtl/ksa_cell.sv]
// One slot of the allocator: owner key, expiry time and the registered compare flags.
// Depends on ksa_pkg; instantiated in a row by keyed_slot_allocator_with_expiry.
module ksa_cell import ksa_pkg::*; #(
  parameter bit IsFirst = 1'b0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  req_t       req_i,
  input  cell_ctrl_t ctrl_i,
  input  chain_t     chain_i,
  input  chain_sum_t sum_i,
  output chain_t     chain_o,
  output logic       grant_o
);

  logic [KeyW-1:0]  owner_q, owner_d;
  logic [TimeW-1:0] expiry_q, expiry_d;
  logic             match_q, match_d;
  logic             exp_q, exp_d;

  always_comb begin
    match_d  = match_q;
    exp_d    = exp_q;
    owner_d  = owner_q;
    expiry_d = expiry_q;
    if (ctrl_i.cmp_en) begin
      match_d = (req_i.key != '0) && (owner_q == req_i.key);
      exp_d   = expiry_q < req_i.now;
    end
    if (ctrl_i.wr_en && grant_o) begin
      owner_d  = req_i.key;
      expiry_d = req_i.expiry;
    end
  end

  // Pass on whether this or any lower slot has a key match or an expired entry.
  assign chain_o.match_seen = chain_i.match_seen | match_q;
  assign chain_o.exp_seen   = chain_i.exp_seen | exp_q;

  always_comb begin
    priority if (sum_i.any_match) begin
      grant_o = match_q & ~chain_i.match_seen;
    end else if (sum_i.any_exp) begin
      grant_o = exp_q & ~chain_i.exp_seen;
    end else begin
      grant_o = IsFirst;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_q  <= '0;
      expiry_q <= '0;
      match_q  <= 1'b0;
      exp_q    <= 1'b0;
    end else begin
      owner_q  <= owner_d;
      expiry_q <= expiry_d;
      match_q  <= match_d;
      exp_q    <= exp_d;
    end
  end

endmodule

[hw/rtl/keyed_slot_allocator_with_expiry.sv]
// Top level of the keyed slot allocator with expiry: request capture, sequencer,
// row of ksa_cell slots and the result register. Depends on ksa_pkg and ksa_cell.
//
//   channel   dir  fields (tdata, lowest bit first)
//   s_axis    in   owner_key[15:0], now_ms[47:16], lifetime_ms[63:48]
//   m_axis    out  slot_index[4:0], found_by[6:5], zero pad[7]
//
// Each request passes through a compare state, which compares the request against
// every slot and registers the flags, and a grant state, which resolves the priority
// chain across the cell row, writes the granted slot and loads the result register.
// The next request is taken in the grant state, while the current one finishes.
// A stalled result holds the sequencer in the grant cycle until it is taken.
// Reset clears every slot at once (key 0, expiry 0); no clearing pass.
module keyed_slot_allocator_with_expiry import ksa_pkg::*; #(
  parameter int unsigned SLOT_COUNT = SlotCountDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // owner_key[15:0], now_ms[47:16], lifetime_ms[63:48]
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // slot_index[4:0], found_by[6:5], zero[7]
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i
);

  ksa_state_e state_q, state_d;

  req_t       req_q, req_d;
  cell_ctrl_t ctrl;
  chain_sum_t chain_sum;
  chain_t     chain [SLOT_COUNT+1];
  logic [SLOT_COUNT-1:0] grant;

  logic                out_valid_q, out_valid_d;
  logic [IndexW-1:0]   out_index_q, out_index_d;
  logic [FoundW-1:0]   out_found_q, out_found_d;

  logic              in_fire;
  logic              advance;
  logic [KeyW-1:0]   in_key;
  logic [TimeW-1:0]  in_now;
  logic [LifeW-1:0]  in_life;
  logic [TimeW:0]    exp_sum;
  logic [IndexW-1:0] grant_index;

  assign in_key  = s_axis_tdata_i[KeyW-1:0];
  assign in_now  = s_axis_tdata_i[KeyW+TimeW-1:KeyW];
  assign in_life = s_axis_tdata_i[KeyW+TimeW+LifeW-1:KeyW+TimeW];

  // Saturate the new expiry at the top of the time range.
  assign exp_sum = {1'b0, in_now} + {{(TimeW+1-LifeW){1'b0}}, in_life};

  // The result register can take a new result when empty or being drained.
  assign advance = ~out_valid_q | m_axis_tready_i;
  assign in_fire = s_axis_tvalid_i & s_axis_tready_o;

  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    ctrl            = '0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        ctrl.cmp_en = 1'b1;
        state_d     = ST_GRANT;
      end
      ST_GRANT: begin
        if (advance) begin
          ctrl.wr_en      = 1'b1;
          s_axis_tready_o = 1'b1;
          state_d         = s_axis_tvalid_i ? ST_CMP : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Capture the request; the grant cycle reads the old one before this edge.
  always_comb begin
    req_d = req_q;
    if (in_fire) begin
      req_d.key    = in_key;
      req_d.now    = in_now;
      req_d.expiry = exp_sum[TimeW] ? {TimeW{1'b1}} : exp_sum[TimeW-1:0];
    end
  end

  assign chain[0] = '0;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    ksa_cell #(
      .IsFirst (i == 0)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .req_i   (req_q),
      .ctrl_i  (ctrl),
      .chain_i (chain[i]),
      .sum_i   (chain_sum),
      .chain_o (chain[i+1]),
      .grant_o (grant[i])
    );
  end

  assign chain_sum.any_match = chain[SLOT_COUNT].match_seen;
  assign chain_sum.any_exp   = chain[SLOT_COUNT].exp_seen;

  // Exactly one cell grants; fold its index (low bits only).
  always_comb begin
    grant_index = '0;
    for (int unsigned i = 0; i < SLOT_COUNT; i++) begin
      if (grant[i]) begin
        grant_index = grant_index | IndexW'(i);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_index_d = out_index_q;
    out_found_d = out_found_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (ctrl.wr_en) begin
      out_valid_d = 1'b1;
      out_index_d = grant_index;
      priority if (chain_sum.any_match) begin
        out_found_d = FOUND_KEY;
      end else if (chain_sum.any_exp) begin
        out_found_d = FOUND_EXPIRED;
      end else begin
        out_found_d = FOUND_FORCED;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW-IndexW-FoundW){1'b0}}, out_found_q, out_index_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    out_index_q <= out_index_d;
    out_found_q <= out_found_d;
  end

endmodule
